@@ design/brle_pkg.sv @@
`timescale 1ns / 1ps

package brle_pkg;

    // Longest literal packet. The last literal of a full packet travels in the
    // command itself, so the store never holds more than LITERAL_MAX - 1 bytes.
    localparam int LITERAL_MAX = 127;
    localparam int CNT_W       = $clog2(LITERAL_MAX + 1);
    localparam int ADDR_W      = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] REP_FLAG = 8'h80;
    localparam logic [6:0] REP_MAX  = 7'h7F;

    // One packet for the back end: the header, then nstore bytes from the
    // literal store, then the tail byte if tail_valid is set.
    typedef struct packed {
        logic [7:0]       hdr;
        logic [CNT_W-1:0] nstore;
        logic             tail_valid;
        logic [7:0]       tail_byte;
        logic             step_end;
        logic             block_end;
    } brle_cmd_t;

    // One stream byte on its way to the packer.
    typedef struct packed {
        logic [7:0] data;
        logic       step_end;
        logic       block_end;
    } brle_byte_t;

    // Write port of the literal store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } brle_wr_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HEAD,
        B_BODY,
        B_TAIL
    } back_state_t;

endpackage

@@ design/brle_front.sv @@
`timescale 1ns / 1ps

module brle_front
    import brle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       fifo_room2,
    input  logic       store_done,
    output logic       push0_valid,
    output brle_cmd_t  push0_cmd,
    output logic       push1_valid,
    output brle_cmd_t  push1_cmd,
    output brle_wr_t   store_wr
);

    logic [CNT_W-1:0] lit_cnt_reg, lit_cnt_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             rep_mode_reg, rep_mode_next;
    logic [6:0]       rep_cnt_reg, rep_cnt_next;
    logic             store_busy_reg, store_busy_next;

    logic             accept;
    logic             same;
    logic [6:0]       rep_inc;
    logic             cmd_a_valid;
    logic             cmd_b_valid;
    brle_cmd_t        cmd_a;
    brle_cmd_t        cmd_b;
    brle_wr_t         wr;

    assign in_stall = store_busy_reg || !fifo_room2;
    assign accept   = in_valid && !in_stall;
    assign same     = (in_byte == pend_byte_reg);
    assign rep_inc  = rep_cnt_reg + 7'd1;

    // Classify the request: the main step may close one packet and the end of
    // a block may close a second one.
    always_comb
    begin
        cmd_a_valid     = 1'b0;
        cmd_b_valid     = 1'b0;
        cmd_a           = '0;
        cmd_b           = '0;
        wr              = '0;
        lit_cnt_next    = lit_cnt_reg;
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        rep_mode_next   = rep_mode_reg;
        rep_cnt_next    = rep_cnt_reg;

        if (!pend_valid_reg)
        begin
            pend_byte_next  = in_byte;
            pend_valid_next = 1'b1;
        end
        else if (rep_mode_reg)
        begin
            if (same)
            begin
                if (rep_inc == REP_MAX)
                begin
                    cmd_a_valid          = 1'b1;
                    cmd_a.hdr            = REP_FLAG | {1'b0, REP_MAX};
                    cmd_a.tail_valid     = 1'b1;
                    cmd_a.tail_byte      = pend_byte_reg;
                    rep_cnt_next         = '0;
                    pend_valid_next      = 1'b0;
                end
                else
                begin
                    rep_cnt_next = rep_inc;
                end
            end
            else
            begin
                cmd_a_valid      = 1'b1;
                cmd_a.hdr        = REP_FLAG | {1'b0, rep_cnt_reg};
                cmd_a.tail_valid = 1'b1;
                cmd_a.tail_byte  = pend_byte_reg;
                rep_mode_next    = 1'b0;
                rep_cnt_next     = '0;
                pend_byte_next   = in_byte;
            end
        end
        else
        begin
            if (same)
            begin
                if (lit_cnt_reg != '0)
                begin
                    cmd_a_valid  = 1'b1;
                    cmd_a.hdr    = 8'(lit_cnt_reg);
                    cmd_a.nstore = lit_cnt_reg;
                end
                lit_cnt_next  = '0;
                rep_mode_next = 1'b1;
                rep_cnt_next  = 7'd1;
            end
            else
            begin
                if (lit_cnt_reg == CNT_W'(LITERAL_MAX - 1))
                begin
                    // The buffer fills: the held byte closes the packet as its tail.
                    cmd_a_valid      = 1'b1;
                    cmd_a.hdr        = 8'(lit_cnt_reg) + 8'd1;
                    cmd_a.nstore     = lit_cnt_reg;
                    cmd_a.tail_valid = 1'b1;
                    cmd_a.tail_byte  = pend_byte_reg;
                    lit_cnt_next     = '0;
                end
                else
                begin
                    wr.en        = 1'b1;
                    wr.addr      = lit_cnt_reg[ADDR_W-1:0];
                    wr.data      = pend_byte_reg;
                    lit_cnt_next = lit_cnt_reg + CNT_W'(1);
                end
                pend_byte_next = in_byte;
            end
        end

        if (in_last)
        begin
            if (pend_valid_next && rep_mode_next)
            begin
                cmd_b_valid      = 1'b1;
                cmd_b.hdr        = REP_FLAG | {1'b0, rep_cnt_next};
                cmd_b.tail_valid = 1'b1;
                cmd_b.tail_byte  = pend_byte_next;
            end
            else if (pend_valid_next)
            begin
                cmd_b_valid      = 1'b1;
                cmd_b.hdr        = 8'(lit_cnt_next) + 8'd1;
                cmd_b.nstore     = lit_cnt_next;
                cmd_b.tail_valid = 1'b1;
                cmd_b.tail_byte  = pend_byte_next;
            end
            lit_cnt_next    = '0;
            pend_byte_next  = '0;
            pend_valid_next = 1'b0;
            rep_mode_next   = 1'b0;
            rep_cnt_next    = '0;
        end

        cmd_a.step_end  = !cmd_b_valid;
        cmd_a.block_end = in_last && !cmd_b_valid;
        cmd_b.step_end  = 1'b1;
        cmd_b.block_end = in_last;
    end

    assign push0_valid = accept && (cmd_a_valid || cmd_b_valid);
    assign push0_cmd   = cmd_a_valid ? cmd_a : cmd_b;
    assign push1_valid = accept && cmd_a_valid && cmd_b_valid;
    assign push1_cmd   = cmd_b;

    always_comb
    begin
        store_wr    = wr;
        store_wr.en = wr.en && accept;
    end

    // The store is held from the push of a packet that reads it until the
    // back end has read its last byte.
    always_comb
    begin
        if (store_busy_reg)
        begin
            store_busy_next = !store_done;
        end
        else
        begin
            store_busy_next = accept &&
                ((cmd_a_valid && (cmd_a.nstore != '0)) ||
                 (cmd_b_valid && (cmd_b.nstore != '0)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_cnt_reg    <= '0;
            pend_byte_reg  <= '0;
            pend_valid_reg <= 1'b0;
            rep_mode_reg   <= 1'b0;
            rep_cnt_reg    <= '0;
            store_busy_reg <= 1'b0;
        end
        else
        begin
            store_busy_reg <= store_busy_next;
            if (accept)
            begin
                lit_cnt_reg    <= lit_cnt_next;
                pend_byte_reg  <= pend_byte_next;
                pend_valid_reg <= pend_valid_next;
                rep_mode_reg   <= rep_mode_next;
                rep_cnt_reg    <= rep_cnt_next;
            end
        end
    end

    a_no_write_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        store_busy_reg |-> !store_wr.en)
        else $error("literal store written while a packet is being read from it");

endmodule

@@ design/brle_cmd_fifo.sv @@
`timescale 1ns / 1ps

module brle_cmd_fifo
    import brle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push0_valid,
    input  brle_cmd_t push0_cmd,
    input  logic      push1_valid,
    input  brle_cmd_t push1_cmd,
    input  logic      pop,
    output brle_cmd_t head,
    output logic      empty,
    output logic      room2
);

    brle_cmd_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign room2 = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push0_valid) + FIFO_PTR_W'(push1_valid);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push0_valid) + FIFO_CNT_W'(push1_valid)
                      - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0_valid)
        begin
            entry_reg[wr_ptr_reg] <= push0_cmd;
        end
        if (push1_valid)
        begin
            entry_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push1_cmd;
        end
    end

endmodule

@@ design/brle_back.sv @@
`timescale 1ns / 1ps

module brle_back
    import brle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  brle_wr_t   store_wr,
    input  brle_cmd_t  fifo_head,
    input  logic       fifo_empty,
    output logic       fifo_pop,
    output logic       byte_valid,
    output brle_byte_t byte_out,
    input  logic       byte_ready,
    output logic       store_done
);

    back_state_t       state_reg, state_next;
    brle_cmd_t         cmd_reg, cmd_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] rd_addr;
    logic              body_last;

    logic [7:0]        store_mem [LITERAL_MAX];
    logic [7:0]        rd_data_reg;

    // The read address follows the byte index, so the registered read data
    // always holds the entry that the body state is about to send.
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign body_last = (CNT_W'(idx_reg) == (cmd_reg.nstore - CNT_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        rd_addr    = '0;
        fifo_pop   = 1'b0;
        byte_valid = 1'b0;
        byte_out   = '0;
        store_done = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop   = 1'b1;
                    cmd_next   = fifo_head;
                    idx_next   = '0;
                    state_next = B_HEAD;
                end
            end
            B_HEAD:
            begin
                byte_valid    = 1'b1;
                byte_out.data = cmd_reg.hdr;
                if (byte_ready)
                begin
                    state_next = (cmd_reg.nstore != '0) ? B_BODY : B_TAIL;
                end
            end
            B_BODY:
            begin
                byte_valid         = 1'b1;
                byte_out.data      = rd_data_reg;
                byte_out.step_end  = body_last && !cmd_reg.tail_valid && cmd_reg.step_end;
                byte_out.block_end = body_last && !cmd_reg.tail_valid && cmd_reg.block_end;
                rd_addr            = idx_reg;
                if (byte_ready)
                begin
                    if (body_last)
                    begin
                        store_done = 1'b1;
                        rd_addr    = '0;
                        state_next = cmd_reg.tail_valid ? B_TAIL : B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                        rd_addr  = idx_reg + ADDR_W'(1);
                    end
                end
            end
            B_TAIL:
            begin
                byte_valid         = 1'b1;
                byte_out.data      = cmd_reg.tail_byte;
                byte_out.step_end  = cmd_reg.step_end;
                byte_out.block_end = cmd_reg.block_end;
                if (byte_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ design/brle_packer.sv @@
`timescale 1ns / 1ps

module brle_packer
    import brle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  brle_byte_t byte_in,
    output logic       byte_ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_byte3,
    output logic [2:0] out_count,
    output logic       out_burst_end,
    output logic       out_block_end
);

    logic [7:0] acc_reg [3];
    logic [1:0] fill_reg, fill_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte0_reg, out_byte1_reg, out_byte2_reg, out_byte3_reg;
    logic [2:0] out_count_reg;
    logic       out_burst_end_reg, out_block_end_reg;

    logic       closes;
    logic       take;
    logic [7:0] word0, word1, word2, word3;

    // A byte closes a result when it is the fourth one or ends the request's
    // output; only then does it need the output register.
    assign closes     = (fill_reg == 2'd3) || byte_in.step_end;
    assign byte_ready = !closes || !out_valid_reg || !out_stall;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        word0 = (fill_reg == 2'd0) ? byte_in.data : acc_reg[0];
        word1 = (fill_reg == 2'd1) ? byte_in.data : ((fill_reg > 2'd1) ? acc_reg[1] : 8'h00);
        word2 = (fill_reg == 2'd2) ? byte_in.data : ((fill_reg == 2'd3) ? acc_reg[2] : 8'h00);
        word3 = (fill_reg == 2'd3) ? byte_in.data : 8'h00;

        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            if (closes)
            begin
                fill_next      = 2'd0;
                out_valid_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (closes)
            begin
                out_byte0_reg     <= word0;
                out_byte1_reg     <= word1;
                out_byte2_reg     <= word2;
                out_byte3_reg     <= word3;
                out_count_reg     <= 3'(fill_reg) + 3'd1;
                out_burst_end_reg <= byte_in.step_end;
                out_block_end_reg <= byte_in.block_end;
            end
            else
            begin
                acc_reg[fill_reg] <= byte_in.data;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte0     = out_byte0_reg;
    assign out_byte1     = out_byte1_reg;
    assign out_byte2     = out_byte2_reg;
    assign out_byte3     = out_byte3_reg;
    assign out_count     = out_count_reg;
    assign out_burst_end = out_burst_end_reg;
    assign out_block_end = out_block_end_reg;

    a_count_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg != 3'd0) && (out_count_reg <= 3'd4))
        else $error("result carries an impossible byte count");

    a_block_ends_burst: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_block_end_reg) |-> out_burst_end_reg)
        else $error("block end flagged on a result that does not end its burst");

    a_unused_lane_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_count_reg != 3'd4)) |-> (out_byte3_reg == 8'h00))
        else $error("unused byte lane of a short result is not zero");

endmodule

@@ design/byte_run_length_encoder_top.sv @@
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake            Payload
//  in       request    in_valid / in_stall   in_byte[7:0], in_last
//  out      result     out_valid / out_stall out_byte0..3[7:0], out_count[2:0],
//                                            out_burst_end, out_block_end
//
//  The front end takes one byte request per cycle while the command queue has two
//  free slots and no literal packet is still waiting to be read out of the
//  literal store. The back end fetches a command in its idle state and then sends
//  one stream byte per cycle into the packer while the packer is ready. A literal
//  packet holds input from its push until the back end has read its last stored
//  byte. rst_n clears all control state at once; the literal store has no reset
//  and needs no clearing pass. A stalled output holds its result while the packer
//  keeps collecting bytes of the next one.
//

module byte_run_length_encoder_top
    import brle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_byte3,
    output logic [2:0] out_count,
    output logic       out_burst_end,
    output logic       out_block_end
);

    // Commands from the front end: a request closes at most two packets, so the
    // queue takes two entries in one cycle.
    logic       push0_valid;
    logic       push1_valid;
    brle_cmd_t  push0_cmd;
    brle_cmd_t  push1_cmd;
    logic       fifo_room2;
    logic       fifo_empty;
    logic       fifo_pop;
    brle_cmd_t  fifo_head;

    // The front end writes literals into the store inside the back end, which
    // reports when it has read the last byte of the packet that uses them.
    brle_wr_t   store_wr;
    logic       store_done;

    // Byte stream from the back end into the result packer.
    logic       byte_valid;
    logic       byte_ready;
    brle_byte_t byte_bus;

    brle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .fifo_room2  (fifo_room2),
        .store_done  (store_done),
        .push0_valid (push0_valid),
        .push0_cmd   (push0_cmd),
        .push1_valid (push1_valid),
        .push1_cmd   (push1_cmd),
        .store_wr    (store_wr)
    );

    brle_cmd_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push0_valid (push0_valid),
        .push0_cmd   (push0_cmd),
        .push1_valid (push1_valid),
        .push1_cmd   (push1_cmd),
        .pop         (fifo_pop),
        .head        (fifo_head),
        .empty       (fifo_empty),
        .room2       (fifo_room2)
    );

    brle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .store_wr   (store_wr),
        .fifo_head  (fifo_head),
        .fifo_empty (fifo_empty),
        .fifo_pop   (fifo_pop),
        .byte_valid (byte_valid),
        .byte_out   (byte_bus),
        .byte_ready (byte_ready),
        .store_done (store_done)
    );

    // Packs the stream into results of up to four bytes, closing a result early
    // at the last byte that a request produced.
    brle_packer u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_in       (byte_bus),
        .byte_ready    (byte_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte0     (out_byte0),
        .out_byte1     (out_byte1),
        .out_byte2     (out_byte2),
        .out_byte3     (out_byte3),
        .out_count     (out_count),
        .out_burst_end (out_burst_end),
        .out_block_end (out_block_end)
    );

endmodule
